>>> hdl/tics_pkg.sv
// ----------------------------------------------------------------------------
// tics_pkg
// Types and constants shared by the track isolation cone sum block.
// ----------------------------------------------------------------------------
package tics_pkg;

   localparam int ETA_W   = 14;
   localparam int PHI_W   = 13;
   localparam int Z_W     = 15;
   localparam int PT_W    = 16;
   localparam int HITS_W  = 6;
   localparam int PIX_W   = 4;
   localparam int SUM_W   = 24;
   localparam int DIST2_W = 30;
   localparam int RATIO_W = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 30;

   localparam logic [HITS_W-1:0] MIN_HITS       = 6'd8;
   localparam logic [PIX_W-1:0]  MIN_PIXEL_HITS = 4'd1;
   localparam logic [ETA_W-1:0]  MIN_ETA_GAP    = 14'd0;

   typedef enum logic [1:0] {
      KIND_REF  = 2'd0,
      KIND_VETO = 2'd1,
      KIND_CAND = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PID_ACCEPT_ALL  = 2'd0,
      PID_REJECT_MUON = 2'd1,
      PID_ONLY_MUON   = 2'd2
   } pid_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_CONE_DIST2   = 3'd0,
      REG_MAX_CONE_DIST2   = 3'd1,
      REG_MAX_DZ           = 3'd2,
      REG_MIN_TRACK_PT     = 3'd3,
      REG_VETO_DETA        = 3'd4,
      REG_VETO_DPHI        = 3'd5,
      REG_MAX_PT_ERR_RATIO = 3'd6,
      REG_PID_VETO_MODE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIST2_W-1:0]        min_cone_dist2;
      logic [DIST2_W-1:0]        max_cone_dist2;
      logic [Z_W-1:0]            max_dz;
      logic [PT_W-1:0]           min_track_pt;
      logic [ETA_W-1:0]          veto_deta;
      logic [PHI_W-1:0]          veto_dphi;
      logic signed [RATIO_W-1:0] max_pt_err_ratio;
      logic [1:0]                pid_veto_mode;
   } cfg_type;

   typedef struct packed {
      logic            add;
      logic [PT_W-1:0] pt;
      logic            last;
   } entry_type;

endpackage

>>> hdl/tics_if.sv
// ----------------------------------------------------------------------------
// tics_if
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface tics_req_if;
   import tics_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic signed [ETA_W-1:0]  eta;
   logic signed [PHI_W-1:0]  phi;
   logic signed [Z_W-1:0]    z_pos;
   logic [PT_W-1:0]          pt;
   logic [PT_W-1:0]          pt_err;
   logic [HITS_W-1:0]        valid_hits;
   logic [PIX_W-1:0]         pixel_hits;
   logic                     is_muon;
   logic                     track_ok;
   logic                     last;

   modport source (output valid, kind, eta, phi, z_pos, pt, pt_err, valid_hits,
                   pixel_hits, is_muon, track_ok, last, input ready);
   modport sink (input valid, kind, eta, phi, z_pos, pt, pt_err, valid_hits,
                 pixel_hits, is_muon, track_ok, last, output ready);
endinterface

interface tics_rsp_if;
   import tics_pkg::*;

   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] iso_sum;

   modport source (output valid, iso_sum, input ready);
   modport sink (input valid, iso_sum, output ready);
endinterface

interface tics_csr_if;
   import tics_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/tics_csr.sv
// ----------------------------------------------------------------------------
// tics_csr
// Cut set register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module tics_csr (
   input  logic           clock,
   input  logic           reset,
   tics_csr_if.sink       csr_if,
   output tics_pkg::cfg_type cfg
);
   import tics_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            REG_MIN_CONE_DIST2:   cfg_in.min_cone_dist2 = csr_if.data[DIST2_W-1:0];
            REG_MAX_CONE_DIST2:   cfg_in.max_cone_dist2 = csr_if.data[DIST2_W-1:0];
            REG_MAX_DZ:           cfg_in.max_dz = csr_if.data[Z_W-1:0];
            REG_MIN_TRACK_PT:     cfg_in.min_track_pt = csr_if.data[PT_W-1:0];
            REG_VETO_DETA:        cfg_in.veto_deta = csr_if.data[ETA_W-1:0];
            REG_VETO_DPHI:        cfg_in.veto_dphi = csr_if.data[PHI_W-1:0];
            REG_MAX_PT_ERR_RATIO: cfg_in.max_pt_err_ratio = csr_if.data[RATIO_W-1:0];
            REG_PID_VETO_MODE:    cfg_in.pid_veto_mode = csr_if.data[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_cone_dist2   <= '0;
         cfg_ff.max_cone_dist2   <= '1;
         cfg_ff.max_dz           <= '1;
         cfg_ff.min_track_pt     <= '0;
         cfg_ff.veto_deta        <= '0;
         cfg_ff.veto_dphi        <= '0;
         cfg_ff.max_pt_err_ratio <= '1;
         cfg_ff.pid_veto_mode    <= PID_ACCEPT_ALL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/tics_front.sv
// ----------------------------------------------------------------------------
// tics_front
// Loads the reference and veto tracks and runs the cuts on every candidate
// in a three stage pipeline: distances, products, window checks.
// ----------------------------------------------------------------------------
module tics_front (
   input  logic                clock,
   input  logic                reset,
   tics_req_if.sink            req_if,
   input  tics_pkg::cfg_type   cfg,
   output logic                push_valid,
   input  logic                push_ready,
   output tics_pkg::entry_type push_entry
);
   import tics_pkg::*;

   localparam int SQ_ETA_W = 2 * ETA_W;
   localparam int SQ_PHI_W = 2 * PHI_W;
   localparam int PROD_W   = (RATIO_W - 1) + PT_W;
   localparam int ERR_W    = PT_W + 8;

   logic enable;
   logic accept;

   logic signed [ETA_W-1:0] ref_eta_ff, ref_eta_in;
   logic signed [PHI_W-1:0] ref_phi_ff, ref_phi_in;
   logic signed [Z_W-1:0]   ref_z_ff, ref_z_in;
   logic signed [ETA_W-1:0] second_eta_ff, second_eta_in;
   logic signed [PHI_W-1:0] second_phi_ff, second_phi_in;

   // Stage one: magnitudes of the differences and the simple track cuts.
   logic              s1_valid_ff, s1_valid_in;
   logic [ETA_W-1:0]  s1_deta_ff, s1_deta_in;
   logic [PHI_W-1:0]  s1_dphi_ff, s1_dphi_in;
   logic [ETA_W-1:0]  s1_vdeta_ff, s1_vdeta_in;
   logic [PHI_W-1:0]  s1_vdphi_ff, s1_vdphi_in;
   logic [Z_W-1:0]    s1_dz_ff, s1_dz_in;
   logic [PT_W-1:0]   s1_pt_ff, s1_pt_in;
   logic [PT_W-1:0]   s1_pt_err_ff, s1_pt_err_in;
   logic              s1_ok_ff, s1_ok_in;
   logic              s1_last_ff, s1_last_in;

   // Stage two: squares, ratio product and the dz, eta gap and veto compares.
   logic                s2_valid_ff, s2_valid_in;
   logic [SQ_ETA_W-1:0] s2_deta_sq_ff, s2_deta_sq_in;
   logic [SQ_PHI_W-1:0] s2_dphi_sq_ff, s2_dphi_sq_in;
   logic [PROD_W-1:0]   s2_ratio_prod_ff, s2_ratio_prod_in;
   logic [ERR_W-1:0]    s2_err_ff, s2_err_in;
   logic [PT_W-1:0]     s2_pt_ff, s2_pt_in;
   logic                s2_ok_ff, s2_ok_in;
   logic                s2_last_ff, s2_last_in;

   logic      s3_valid_ff, s3_valid_in;
   entry_type s3_entry_ff, s3_entry_in;

   logic signed [ETA_W:0]   eta_diff;
   logic signed [ETA_W:0]   veta_diff;
   logic [PHI_W-1:0]        phi_diff;
   logic [PHI_W-1:0]        vphi_diff;
   logic signed [Z_W:0]     z_diff;
   logic                    pid_ok;
   logic [DIST2_W-1:0]      dr2;
   logic                    ratio_ok;

   assign enable       = !s3_valid_ff || push_ready;
   assign req_if.ready = enable;
   assign accept       = req_if.valid && enable;
   assign push_valid   = s3_valid_ff;
   assign push_entry   = s3_entry_ff;

   always_comb begin
      ref_eta_in    = ref_eta_ff;
      ref_phi_in    = ref_phi_ff;
      ref_z_in      = ref_z_ff;
      second_eta_in = second_eta_ff;
      second_phi_in = second_phi_ff;
      if (accept) begin
         unique case (req_if.kind)
            KIND_REF: begin
               ref_eta_in = req_if.eta;
               ref_phi_in = req_if.phi;
               ref_z_in   = req_if.z_pos;
            end
            KIND_VETO: begin
               second_eta_in = req_if.eta;
               second_phi_in = req_if.phi;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      eta_diff  = {req_if.eta[ETA_W-1], req_if.eta} - {ref_eta_ff[ETA_W-1], ref_eta_ff};
      veta_diff = {second_eta_ff[ETA_W-1], second_eta_ff} - {req_if.eta[ETA_W-1], req_if.eta};
      phi_diff  = ref_phi_ff - req_if.phi;
      vphi_diff = second_phi_ff - req_if.phi;
      z_diff    = {ref_z_ff[Z_W-1], ref_z_ff} - {req_if.z_pos[Z_W-1], req_if.z_pos};

      unique case (cfg.pid_veto_mode)
         PID_REJECT_MUON: pid_ok = !req_if.is_muon;
         PID_ONLY_MUON:   pid_ok = req_if.is_muon;
         default:         pid_ok = 1'b1;
      endcase

      s1_valid_in  = accept && (req_if.kind == KIND_CAND);
      s1_deta_in   = eta_diff[ETA_W] ? ETA_W'(-eta_diff) : eta_diff[ETA_W-1:0];
      s1_vdeta_in  = veta_diff[ETA_W] ? ETA_W'(-veta_diff) : veta_diff[ETA_W-1:0];
      s1_dphi_in   = phi_diff[PHI_W-1] ? (~phi_diff + 1'b1) : phi_diff;
      s1_vdphi_in  = vphi_diff[PHI_W-1] ? (~vphi_diff + 1'b1) : vphi_diff;
      s1_dz_in     = z_diff[Z_W] ? Z_W'(-z_diff) : z_diff[Z_W-1:0];
      s1_pt_in     = req_if.pt;
      s1_pt_err_in = req_if.pt_err;
      s1_last_in   = req_if.last;
      s1_ok_in     = (req_if.valid_hits >= MIN_HITS) && (req_if.pixel_hits >= MIN_PIXEL_HITS)
                     && req_if.track_ok && (req_if.pt > cfg.min_track_pt) && pid_ok;
   end

   always_comb begin
      s2_valid_in      = s1_valid_ff;
      s2_deta_sq_in    = SQ_ETA_W'(s1_deta_ff) * SQ_ETA_W'(s1_deta_ff);
      s2_dphi_sq_in    = SQ_PHI_W'(s1_dphi_ff) * SQ_PHI_W'(s1_dphi_ff);
      s2_ratio_prod_in = PROD_W'(cfg.max_pt_err_ratio[RATIO_W-2:0]) * PROD_W'(s1_pt_ff);
      s2_err_in        = {s1_pt_err_ff, 8'd0};
      s2_pt_in         = s1_pt_ff;
      s2_last_in       = s1_last_ff;
      s2_ok_in         = s1_ok_ff && (s1_dz_ff < cfg.max_dz) && (s1_deta_ff >= MIN_ETA_GAP)
                         && !((s1_vdeta_ff < cfg.veto_deta) && (s1_vdphi_ff < cfg.veto_dphi));
   end

   always_comb begin
      dr2      = DIST2_W'(s2_deta_sq_ff) + DIST2_W'(s2_dphi_sq_ff);
      ratio_ok = cfg.max_pt_err_ratio[RATIO_W-1] || (PROD_W'(s2_err_ff) < s2_ratio_prod_ff);
      s3_valid_in      = s2_valid_ff;
      s3_entry_in.pt   = s2_pt_ff;
      s3_entry_in.last = s2_last_ff;
      s3_entry_in.add  = s2_ok_ff && ratio_ok && (dr2 >= cfg.min_cone_dist2)
                         && (dr2 <= cfg.max_cone_dist2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_eta_ff    <= '0;
         ref_phi_ff    <= '0;
         ref_z_ff      <= '0;
         second_eta_ff <= '0;
         second_phi_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
      end else begin
         ref_eta_ff    <= ref_eta_in;
         ref_phi_ff    <= ref_phi_in;
         ref_z_ff      <= ref_z_in;
         second_eta_ff <= second_eta_in;
         second_phi_ff <= second_phi_in;
         if (enable) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
            s3_valid_ff <= s3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_deta_ff       <= s1_deta_in;
         s1_dphi_ff       <= s1_dphi_in;
         s1_vdeta_ff      <= s1_vdeta_in;
         s1_vdphi_ff      <= s1_vdphi_in;
         s1_dz_ff         <= s1_dz_in;
         s1_pt_ff         <= s1_pt_in;
         s1_pt_err_ff     <= s1_pt_err_in;
         s1_ok_ff         <= s1_ok_in;
         s1_last_ff       <= s1_last_in;
         s2_deta_sq_ff    <= s2_deta_sq_in;
         s2_dphi_sq_ff    <= s2_dphi_sq_in;
         s2_ratio_prod_ff <= s2_ratio_prod_in;
         s2_err_ff        <= s2_err_in;
         s2_pt_ff         <= s2_pt_in;
         s2_ok_ff         <= s2_ok_in;
         s2_last_ff       <= s2_last_in;
         s3_entry_ff      <= s3_entry_in;
      end
   end

endmodule

>>> hdl/tics_queue.sv
// ----------------------------------------------------------------------------
// tics_queue
// Short first-in first-out queue between the cut pipeline and the summer.
// ----------------------------------------------------------------------------
module tics_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tics_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tics_pkg::entry_type pop_entry
);
   import tics_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   entry_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/tics_back.sv
// ----------------------------------------------------------------------------
// tics_back
// Saturating pt summer and response register.
// ----------------------------------------------------------------------------
module tics_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tics_pkg::entry_type pop_entry,
   tics_rsp_if.source          rsp_if
);
   import tics_pkg::*;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_next;
   logic             pop;

   assign pop_ready      = !pop_entry.last || !rsp_valid_ff || rsp_if.ready;
   assign pop            = pop_valid && pop_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.iso_sum = rsp_sum_ff;

   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(pop_entry.pt);
      if (!pop_entry.add) begin
         sum_next = sum_ff;
      end else if (sum_wide[SUM_W]) begin
         sum_next = '1;
      end else begin
         sum_next = sum_wide[SUM_W-1:0];
      end

      sum_in       = sum_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (pop) begin
         if (pop_entry.last) begin
            sum_in       = '0;
            rsp_sum_in   = sum_next;
            rsp_valid_in = 1'b1;
         end else begin
            sum_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

endmodule

>>> hdl/track_isolation_cone_sum_core.sv
// ----------------------------------------------------------------------------
// track_isolation_cone_sum_core
// Sums the pt of candidate tracks that pass the isolation cuts around a
// reference muon and reports the sum on the candidate marked last.
//
//   Channel  Direction  Carries
//   csr_if   in         register index and write data, always ready
//   req_if   in         reference, veto and candidate track transactions
//   rsp_if   out        iso_sum, one transaction per last candidate
//
// One request transaction is taken every cycle while the response side keeps
// up. A candidate passes three pipeline stages of cuts and then the queue;
// the response of a last candidate is registered once it leaves the queue.
// Reset is synchronous. Response stalls only hold back last candidates; the
// request side stalls once the queue and the final cut stage are both full.
// ----------------------------------------------------------------------------
module track_isolation_cone_sum_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   tics_csr_if.sink   csr_if,
   tics_req_if.sink   req_if,
   tics_rsp_if.source rsp_if
);
   import tics_pkg::*;

   cfg_type   cfg;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   tics_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   tics_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   tics_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   tics_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule
